FILE: rtl/core/pid_controller_clamped_defines.svh
// Assertion macros shared by the PID datapath files.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pcc_pkg.sv
package pcc_pkg;

    // Field and register widths
    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 32;
    localparam int TIME_W     = 16;
    localparam int RATE_W     = 24;
    localparam int ILIM_W     = 47;
    localparam int OLIM_W     = 39;
    localparam int INTEG_W    = 48;
    localparam int DRIVE_W    = 40;
    localparam int CFG_DATA_W = 47;
    localparam int CFG_IDX_W  = 3;

    // Internal widths
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DERIV_W = 41;
    localparam int SUM_W   = INTEG_W + 1;
    localparam int ACC_W   = 67;

    // Serial multiplier: multiplicand a is loaded whole, multiplier b is consumed one bit
    // per cycle, lowest first, sign bit last.
    localparam int MUL_AW    = 48;
    localparam int MUL_BW    = 33;
    localparam int MUL_PW    = MUL_AW + MUL_BW;
    localparam int MUL_CNT_W = 6;

    // Product slices
    localparam int EDT_MSB   = 31;
    localparam int PTERM_MSB = 47;
    localparam int ITERM_MSB = 79;
    localparam int ITERM_LSB = 16;
    localparam int DTERM_MSB = 72;
    localparam int DTERM_LSB = 8;

    localparam logic [TIME_W-1:0] STEP_TIME_RST = 16'd655;
    localparam logic [RATE_W-1:0] STEP_RATE_RST = 24'd25600;

    localparam logic signed [ACC_W-1:0] INTEG_SAT_MAX =
        {{(ACC_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] DRIVE_SAT_MAX =
        {{(ACC_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP   = 3'd0,
        CFG_GAIN_INTEG  = 3'd1,
        CFG_GAIN_DERIV  = 3'd2,
        CFG_STEP_TIME   = 3'd3,
        CFG_STEP_RATE   = 3'd4,
        CFG_INTEG_LIMIT = 3'd5,
        CFG_OUT_LIMIT   = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDT,
        S_ICLAMP,
        S_DR,
        S_EKP,
        S_IKI,
        S_DKD,
        S_DONE
    } pcc_state_t;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_AW-1:0]  a;
        logic signed [MUL_BW-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic signed [MUL_PW-1:0]  product;
    } mul_rsp_t;

endpackage

FILE: rtl/core/pcc_serial_mult.sv
`include "pid_controller_clamped_defines.svh"

module pcc_serial_mult
    import pcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic signed [MUL_AW-1:0]    a_reg;
    logic signed [MUL_AW+1:0]    hi_reg;
    logic        [MUL_BW-1:0]    lo_reg;
    logic        [MUL_CNT_W-1:0] count_reg, count_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic                        last;
    logic signed [MUL_AW+1:0]    a_ext;
    logic signed [MUL_AW+1:0]    partial;
    logic signed [MUL_AW+1:0]    sum;

    assign last  = (count_reg == MUL_CNT_W'(MUL_BW - 1));
    assign a_ext = {{2{a_reg[MUL_AW-1]}}, a_reg};

    // The sign bit of b carries negative weight: subtract on the last step.
    always_comb
    begin
        if (!lo_reg[0])
        begin
            partial = '0;
        end
        else if (last)
        begin
            partial = -a_ext;
        end
        else
        begin
            partial = a_ext;
        end
        sum = hi_reg + partial;
    end

    always_comb
    begin
        done_next  = busy_reg && last;
        busy_next  = busy_reg && !last;
        count_next = count_reg + MUL_CNT_W'(1);
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Shift the partial product right one bit per step; product bits enter lo_reg
    // as multiplier bits leave it.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[MUL_AW+1], sum[MUL_AW+1:1]};
            lo_reg <= {sum[0], lo_reg[MUL_BW-1:1]};
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = {hi_reg[MUL_AW-1:0], lo_reg};

    `PCC_ASSERT_NEXT(a_mul_finish, clk, rst_n, busy_reg && last, done_reg && !busy_reg, "multiplier did not finish after last step")
    `PCC_ASSERT(a_mul_done_idle, clk, rst_n, done_reg, !busy_reg, "done raised while still busy")
    `PCC_ASSERT(a_mul_no_restart, clk, rst_n, req.start, !busy_reg, "multiply started while busy")

endmodule

FILE: rtl/core/pcc_limit.sv
module pcc_limit
    import pcc_pkg::*;
(
    input  logic signed [ACC_W-1:0]  value,
    input  logic signed [ACC_W-1:0]  sat_max,
    input  logic        [ILIM_W-1:0] bound,
    output logic signed [ACC_W-1:0]  result,
    output logic                     clamped
);

    logic signed [ACC_W-1:0] bound_ext;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;

    // A nonzero bound never exceeds the word range, so it replaces saturation.
    always_comb
    begin
        bound_ext = {{(ACC_W-ILIM_W){1'b0}}, bound};
        if (bound != '0)
        begin
            hi = bound_ext;
            lo = -bound_ext;
        end
        else
        begin
            hi = sat_max;
            lo = ~sat_max;
        end

        priority if (value > hi)
        begin
            result  = hi;
            clamped = 1'b1;
        end
        else if (value < lo)
        begin
            result  = lo;
            clamped = 1'b1;
        end
        else
        begin
            result  = value;
            clamped = 1'b0;
        end
    end

endmodule

FILE: rtl/core/pid_controller_clamped.sv
// Channel   Handshake              Word
// input     in_valid / in_ready    error_sample
// output    out_valid / out_ready  drive, integ_clamped, out_clamped
// config    cfg_we (no wait)       cfg_index, cfg_data
//
// One error word at a time runs through five products on a shared bit-serial
// multiplier; the output word is registered once all five are done, and the next
// word can be taken in the cycle after the output word is registered.
// Reset clears the integral, the previous error and all control; step time and
// step rate reset to their nominal values, gains and limits to zero.
// A result held by out_ready stalls only the final load; the previous result
// stays in the output register while the next word is computed.
`include "pid_controller_clamped_defines.svh"

module pid_controller_clamped
    import pcc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [ERR_W-1:0]   error_sample,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive,
    output logic                      integ_clamped,
    output logic                      out_clamped,

    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic signed [GAIN_W-1:0]  gain_prop_reg;
    logic signed [GAIN_W-1:0]  gain_integ_reg;
    logic signed [GAIN_W-1:0]  gain_deriv_reg;
    logic        [TIME_W-1:0]  step_time_reg;
    logic        [RATE_W-1:0]  step_rate_reg;
    logic        [ILIM_W-1:0]  integ_limit_reg;
    logic        [OLIM_W-1:0]  out_limit_reg;

    // Controller state
    pcc_state_t                state_reg, state_next;
    logic signed [INTEG_W-1:0] integ_sum_reg;
    logic signed [ERR_W-1:0]   last_error_reg;

    // Working registers
    logic signed [ERR_W-1:0]   e_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [DERIV_W-1:0] deriv_reg;
    logic signed [ACC_W-1:0]   yacc_reg;
    logic                      iclamp_reg;

    // Output word
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic                      integ_clamped_reg;
    logic                      out_clamped_reg;

    // Shared units
    mul_req_t                  mul_req;
    mul_rsp_t                  mul_rsp;
    logic signed [ACC_W-1:0]   lim_value;
    logic signed [ACC_W-1:0]   lim_max;
    logic        [ILIM_W-1:0]  lim_bound;
    logic signed [ACC_W-1:0]   lim_result;
    logic                      lim_clamped;

    logic signed [DIFF_W-1:0]  diff;
    logic                      out_load;

    pcc_serial_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    pcc_limit u_limit (
        .value   (lim_value),
        .sat_max (lim_max),
        .bound   (lim_bound),
        .result  (lim_result),
        .clamped (lim_clamped)
    );

    assign diff = {e_reg[ERR_W-1], e_reg} - {last_error_reg[ERR_W-1], last_error_reg};

    // Register writes; unknown indexes drop silently.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg   <= '0;
            gain_integ_reg  <= '0;
            gain_deriv_reg  <= '0;
            step_time_reg   <= STEP_TIME_RST;
            step_rate_reg   <= STEP_RATE_RST;
            integ_limit_reg <= '0;
            out_limit_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN_PROP:   gain_prop_reg   <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_INTEG:  gain_integ_reg  <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_DERIV:  gain_deriv_reg  <= cfg_data[GAIN_W-1:0];
                CFG_STEP_TIME:   step_time_reg   <= cfg_data[TIME_W-1:0];
                CFG_STEP_RATE:   step_rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_data[ILIM_W-1:0];
                CFG_OUT_LIMIT:   out_limit_reg   <= cfg_data[OLIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // Next state: each multiply state advances when its product is done.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EDT;
                end
            end
            S_EDT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_ICLAMP;
                end
            end
            S_ICLAMP:
            begin
                state_next = S_DR;
            end
            S_DR:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_EKP;
                end
            end
            S_EKP:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_IKI;
                end
            end
            S_IKI:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_DKD;
                end
            end
            S_DKD:
            begin
                if (mul_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller outputs: multiplier operands, limiter operands, handshakes.
    always_comb
    begin
        in_ready      = 1'b0;
        out_load      = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = {{(MUL_AW-ERR_W){e_reg[ERR_W-1]}}, e_reg};
        mul_req.b     = {{(MUL_BW-GAIN_W){gain_prop_reg[GAIN_W-1]}}, gain_prop_reg};
        lim_value     = yacc_reg;
        lim_max       = DRIVE_SAT_MAX;
        lim_bound     = {{(ILIM_W-OLIM_W){1'b0}}, out_limit_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                // e * dt
                in_ready      = 1'b1;
                mul_req.start = in_valid;
                mul_req.a     = {{(MUL_AW-ERR_W){error_sample[ERR_W-1]}}, error_sample};
                mul_req.b     = {{(MUL_BW-TIME_W){1'b0}}, step_time_reg};
            end
            S_ICLAMP:
            begin
                // (e - last e) * rate; limit the new integral meanwhile
                mul_req.start = 1'b1;
                mul_req.a     = {{(MUL_AW-DIFF_W){diff[DIFF_W-1]}}, diff};
                mul_req.b     = {{(MUL_BW-RATE_W){1'b0}}, step_rate_reg};
                lim_value     = {{(ACC_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
                lim_max       = INTEG_SAT_MAX;
                lim_bound     = integ_limit_reg;
            end
            S_DR:
            begin
                // e * kp
                mul_req.start = mul_rsp.done;
            end
            S_EKP:
            begin
                // I * ki
                mul_req.start = mul_rsp.done;
                mul_req.a     = integ_sum_reg;
                mul_req.b     = {{(MUL_BW-GAIN_W){gain_integ_reg[GAIN_W-1]}}, gain_integ_reg};
            end
            S_IKI:
            begin
                // D * kd
                mul_req.start = mul_rsp.done;
                mul_req.a     = {{(MUL_AW-DERIV_W){deriv_reg[DERIV_W-1]}}, deriv_reg};
                mul_req.b     = {{(MUL_BW-GAIN_W){gain_deriv_reg[GAIN_W-1]}}, gain_deriv_reg};
            end
            S_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            integ_sum_reg  <= '0;
            last_error_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ICLAMP)
            begin
                integ_sum_reg  <= lim_result[INTEG_W-1:0];
                last_error_reg <= e_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: fold each finished product into its destination.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            e_reg <= error_sample;
        end
        if (mul_rsp.done)
        begin
            unique case (state_reg)
                S_EDT:
                begin
                    sum_reg <= {integ_sum_reg[INTEG_W-1], integ_sum_reg}
                             + {{(SUM_W-EDT_MSB-1){mul_rsp.product[EDT_MSB]}},
                                mul_rsp.product[EDT_MSB:0]};
                end
                S_DR:
                begin
                    deriv_reg <= mul_rsp.product[DERIV_W-1:0];
                end
                S_EKP:
                begin
                    yacc_reg <= {{(ACC_W-PTERM_MSB-1){mul_rsp.product[PTERM_MSB]}},
                                 mul_rsp.product[PTERM_MSB:0]};
                end
                S_IKI:
                begin
                    // floor(I * ki / 2^16) by dropping the low product bits
                    yacc_reg <= yacc_reg
                              + {{(ACC_W-ITERM_MSB+ITERM_LSB-1){mul_rsp.product[ITERM_MSB]}},
                                 mul_rsp.product[ITERM_MSB:ITERM_LSB]};
                end
                S_DKD:
                begin
                    // floor(D * kd / 2^8)
                    yacc_reg <= yacc_reg
                              + {{(ACC_W-DTERM_MSB+DTERM_LSB-1){mul_rsp.product[DTERM_MSB]}},
                                 mul_rsp.product[DTERM_MSB:DTERM_LSB]};
                end
                default:
                begin
                    yacc_reg <= yacc_reg;
                end
            endcase
        end
        if (state_reg == S_ICLAMP)
        begin
            iclamp_reg <= lim_clamped;
        end
        if (out_load)
        begin
            drive_reg         <= lim_result[DRIVE_W-1:0];
            out_clamped_reg   <= lim_clamped;
            integ_clamped_reg <= iclamp_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive         = drive_reg;
    assign integ_clamped = integ_clamped_reg;
    assign out_clamped   = out_clamped_reg;

    `PCC_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_reg == S_EDT && mul_rsp.busy, "accepted word did not start a multiply")
    `PCC_ASSERT(a_done_in_wait, clk, rst_n, mul_rsp.done, state_reg == S_EDT || state_reg == S_DR || state_reg == S_EKP || state_reg == S_IKI || state_reg == S_DKD, "product finished outside a multiply state")
    `PCC_ASSERT_NEXT(a_result_posted, clk, rst_n, out_load, out_valid_reg && state_reg == S_IDLE, "result load did not post a word")

endmodule
